// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the console writer checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define TCW_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- hdl/tcw_pkg.sv -----
// ---------------------------------------------------------------------------
// tcw_pkg
// Types, constants and helpers shared by the text console writer.
// ---------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

	localparam int COLUMNS     = 80;
	localparam int ROWS        = 25;
	localparam int CELLS       = COLUMNS * ROWS;

	localparam int KIND_W      = 2;
	localparam int ROW_W       = 5;
	localparam int COL_W       = 7;
	localparam int LOC_W       = 11;
	localparam int CHAR_W      = 8;
	localparam int COLOUR_W    = 8;
	localparam int CELL_W      = 16;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;
	localparam int REG_IDX_W   = 1;

	localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_TEXT_COLOUR   = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_CURSOR_FOLLOW = 1'b1;

	localparam logic [CHAR_W-1:0]   NEWLINE_CODE = 8'h0A;
	localparam logic [CHAR_W-1:0]   SPACE_CODE   = 8'h20;
	localparam logic [COLOUR_W-1:0] RESET_COLOUR = 8'h0F;
	localparam logic                RESET_FOLLOW = 1'b1;
	localparam logic [CELL_W-1:0]   RESET_BLANK  = {RESET_COLOUR, SPACE_CODE};

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CHAR_W-1:0] char_code;
		logic [LOC_W-1:0]  cell_index;
	} req_t;

	typedef struct packed {
		logic [ROW_W-1:0]  cursor_row;
		logic [COL_W-1:0]  cursor_column;
		logic [LOC_W-1:0]  cursor_location;
		logic              cursor_port_update;
		logic              scrolled;
		logic [CELL_W-1:0] read_cell;
	} res_t;

	typedef enum logic [2:0] {
		OP_PUT,
		OP_NEWLINE,
		OP_READ,
		OP_CLEAR,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [CHAR_W-1:0] char_code;
		logic [LOC_W-1:0]  cell_index;
	} cmd_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_SCROLL,
		S_DRAIN,
		S_FILL,
		S_READ,
		S_EMIT
	} state_t;

	// Linear cell address of a cursor position (constant multiply).
	function automatic logic [LOC_W-1:0] cell_loc(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		logic [LOC_W-1:0] loc;
		loc = LOC_W'(row) * LOC_W'(COLUMNS) + LOC_W'(col);
		return loc;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/tcw_ram.sv -----
// ---------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/tcw_front.sv -----
// ---------------------------------------------------------------------------
// tcw_front
// Request intake: registers a request and decodes it into an engine command.
// ---------------------------------------------------------------------------
`default_nettype none

module tcw_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire tcw_pkg::req_t req_data,
	input  wire logic          init_busy,
	input  wire logic          q_full,
	output logic               push,
	output tcw_pkg::cmd_t      cmd
);

	logic          valid_s1;
	tcw_pkg::cmd_t cmd_s1;
	tcw_pkg::cmd_t decoded;
	logic          take;

	// no intake during the power-up clearing pass
	assign req_stall = init_busy | (valid_s1 & q_full);
	assign take      = req_valid & ~req_stall;
	assign push      = valid_s1 & ~q_full;
	assign cmd       = cmd_s1;

	always_comb begin
		decoded.char_code  = req_data.char_code;
		decoded.cell_index = req_data.cell_index;
		unique case (req_data.kind)
			tcw_pkg::KIND_PUT: begin
				decoded.op = (req_data.char_code == tcw_pkg::NEWLINE_CODE) ?
					tcw_pkg::OP_NEWLINE : tcw_pkg::OP_PUT;
			end
			tcw_pkg::KIND_READ: begin
				// reads past the store return zero, same as a no-op
				decoded.op = (req_data.cell_index < tcw_pkg::LOC_W'(tcw_pkg::CELLS)) ?
					tcw_pkg::OP_READ : tcw_pkg::OP_NOP;
			end
			tcw_pkg::KIND_CLEAR: begin
				decoded.op = tcw_pkg::OP_CLEAR;
			end
			default: begin
				decoded.op = tcw_pkg::OP_NOP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take | (valid_s1 & ~push);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= decoded;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/tcw_cmd_queue.sv -----
// ---------------------------------------------------------------------------
// tcw_cmd_queue
// Short command FIFO between the intake and the screen engine.
// ---------------------------------------------------------------------------
`default_nettype none

module tcw_cmd_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire tcw_pkg::cmd_t push_cmd,
	output logic               full,
	input  wire logic          pop,
	output tcw_pkg::cmd_t      head,
	output logic               not_empty
);

	tcw_pkg::cmd_t                 entry_q [tcw_pkg::QUEUE_DEPTH];
	logic [tcw_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [tcw_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [tcw_pkg::QPTR_W:0]      count_q;
	logic                          do_push;
	logic                          do_pop;

	assign full      = count_q == (tcw_pkg::QPTR_W + 1)'(tcw_pkg::QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign do_push   = push & ~full;
	assign do_pop    = pop & not_empty;
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == tcw_pkg::QPTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == tcw_pkg::QPTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/tcw_back.sv -----
// ---------------------------------------------------------------------------
// tcw_back
// Screen engine: cursor, screen RAM, scroll/clear sweeps, result register.
// ---------------------------------------------------------------------------
`default_nettype none

module tcw_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire tcw_pkg::cmd_t                  cmd,
	input  wire logic                           cmd_valid,
	output logic                                pop,
	input  wire logic [tcw_pkg::COLOUR_W-1:0]   text_colour,
	input  wire logic                           cursor_follow,
	output logic                                init_busy,
	output logic                                res_valid,
	input  wire logic                           res_stall,
	output tcw_pkg::res_t                       res_data
);

	localparam logic [tcw_pkg::LOC_W-1:0] LAST_CELL  = tcw_pkg::LOC_W'(tcw_pkg::CELLS - 1);
	localparam logic [tcw_pkg::LOC_W-1:0] ROW_LEN    = tcw_pkg::LOC_W'(tcw_pkg::COLUMNS);
	localparam logic [tcw_pkg::LOC_W-1:0] BOTTOM_ROW =
		tcw_pkg::LOC_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);

	tcw_pkg::state_t state_q, state_d;

	logic [tcw_pkg::LOC_W-1:0]  cnt_q;
	logic [tcw_pkg::ROW_W-1:0]  row_q;
	logic [tcw_pkg::COL_W-1:0]  col_q;
	logic                       scrolled_q;
	logic                       port_q;
	logic [tcw_pkg::CELL_W-1:0] cell_q;
	logic                       wr_pend_s1;
	logic [tcw_pkg::LOC_W-1:0]  wr_addr_s1;
	logic                       res_valid_q;
	tcw_pkg::res_t              res_q;

	// RAM controls
	logic                       ram_we;
	logic [tcw_pkg::LOC_W-1:0]  ram_waddr;
	logic [tcw_pkg::CELL_W-1:0] ram_wdata;
	logic                       ram_re;
	logic [tcw_pkg::LOC_W-1:0]  ram_raddr;
	logic [tcw_pkg::CELL_W-1:0] ram_rdata;

	// cursor arithmetic for the command at the queue head
	logic [tcw_pkg::COL_W-1:0]  col_inc;
	logic                       wrap;
	logic                       line_feed;
	logic                       last_row;
	logic                       is_put;
	logic                       slot_free;
	logic                       emit;
	logic                       sweep_end;

	assign is_put    = (cmd.op == tcw_pkg::OP_PUT) || (cmd.op == tcw_pkg::OP_NEWLINE);
	assign col_inc   = col_q + 1'b1;
	assign wrap      = col_inc == tcw_pkg::COL_W'(tcw_pkg::COLUMNS);
	assign line_feed = (cmd.op == tcw_pkg::OP_NEWLINE) || ((cmd.op == tcw_pkg::OP_PUT) && wrap);
	assign last_row  = row_q == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
	assign slot_free = ~res_valid_q | ~res_stall;
	assign sweep_end = cnt_q == LAST_CELL;

	assign init_busy = state_q == tcw_pkg::S_INIT;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tcw_pkg::S_INIT: begin
				if (sweep_end) state_d = tcw_pkg::S_IDLE;
			end
			tcw_pkg::S_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.op) inside
						tcw_pkg::OP_PUT, tcw_pkg::OP_NEWLINE: begin
							state_d = (line_feed && last_row) ?
								tcw_pkg::S_SCROLL : tcw_pkg::S_EMIT;
						end
						tcw_pkg::OP_READ:  state_d = tcw_pkg::S_READ;
						tcw_pkg::OP_CLEAR: state_d = tcw_pkg::S_FILL;
						default:           state_d = tcw_pkg::S_EMIT;
					endcase
				end
			end
			tcw_pkg::S_SCROLL: begin
				if (sweep_end) state_d = tcw_pkg::S_DRAIN;
			end
			tcw_pkg::S_DRAIN: begin
				state_d = tcw_pkg::S_FILL;
			end
			tcw_pkg::S_FILL: begin
				if (sweep_end) state_d = tcw_pkg::S_EMIT;
			end
			tcw_pkg::S_READ: begin
				state_d = tcw_pkg::S_EMIT;
			end
			tcw_pkg::S_EMIT: begin
				if (slot_free) state_d = tcw_pkg::S_IDLE;
			end
			default: begin
				state_d = tcw_pkg::S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = {text_colour, tcw_pkg::SPACE_CODE};
		ram_re    = 1'b0;
		ram_raddr = cnt_q;
		pop       = 1'b0;
		emit      = 1'b0;
		unique case (state_q)
			tcw_pkg::S_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = tcw_pkg::RESET_BLANK;
			end
			tcw_pkg::S_IDLE: begin
				pop = cmd_valid;
				if (cmd_valid && cmd.op == tcw_pkg::OP_PUT) begin
					ram_we    = 1'b1;
					ram_waddr = tcw_pkg::cell_loc(row_q, col_q);
					ram_wdata = {text_colour, cmd.char_code};
				end
				if (cmd_valid && cmd.op == tcw_pkg::OP_READ) begin
					ram_re    = 1'b1;
					ram_raddr = cmd.cell_index;
				end
			end
			tcw_pkg::S_SCROLL: begin
				// read one row down, write it back one row up in the next cycle
				ram_re    = 1'b1;
				ram_we    = wr_pend_s1;
				ram_waddr = wr_addr_s1;
				ram_wdata = ram_rdata;
			end
			tcw_pkg::S_DRAIN: begin
				ram_we    = wr_pend_s1;
				ram_waddr = wr_addr_s1;
				ram_wdata = ram_rdata;
			end
			tcw_pkg::S_FILL: begin
				ram_we = 1'b1;
			end
			tcw_pkg::S_READ: begin
			end
			tcw_pkg::S_EMIT: begin
				emit = slot_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tcw_pkg::S_INIT;
			cnt_q       <= '0;
			row_q       <= '0;
			col_q       <= '0;
			wr_pend_s1  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			wr_pend_s1 <= state_q == tcw_pkg::S_SCROLL;

			case (state_q) inside
				tcw_pkg::S_INIT, tcw_pkg::S_SCROLL, tcw_pkg::S_FILL: begin
					cnt_q <= cnt_q + 1'b1;
				end
				tcw_pkg::S_DRAIN: begin
					cnt_q <= BOTTOM_ROW;
				end
				tcw_pkg::S_IDLE: begin
					cnt_q <= (cmd.op == tcw_pkg::OP_CLEAR) ? '0 : ROW_LEN;
				end
				default: begin
				end
			endcase

			if (state_q == tcw_pkg::S_IDLE && cmd_valid && is_put) begin
				if (line_feed) begin
					col_q <= '0;
					if (!last_row) begin
						row_q <= row_q + 1'b1;
					end
				end else begin
					col_q <= col_inc;
				end
			end

			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= cnt_q - ROW_LEN;
		if (state_q == tcw_pkg::S_IDLE && cmd_valid) begin
			scrolled_q <= is_put && line_feed && last_row;
			port_q     <= is_put && cursor_follow;
			cell_q     <= '0;
		end
		if (state_q == tcw_pkg::S_READ) begin
			cell_q <= ram_rdata;
		end
		if (emit) begin
			res_q.cursor_row         <= row_q;
			res_q.cursor_column      <= col_q;
			res_q.cursor_location    <= tcw_pkg::cell_loc(row_q, col_q);
			res_q.cursor_port_update <= port_q;
			res_q.scrolled           <= scrolled_q;
			res_q.read_cell          <= cell_q;
		end
	end

	tcw_ram #(
		.WIDTH (tcw_pkg::CELL_W),
		.DEPTH (tcw_pkg::CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire

// ----- hdl/text_console_writer_core.sv -----
// ---------------------------------------------------------------------------
// text_console_writer_core
// Text-mode console engine: 80x25 screen of 16-bit cells, cursor, scroll.
// ---------------------------------------------------------------------------
//
//  channel   signals                              handshake
//  -------   ----------------------------------   ------------------------
//  request   req_valid, req_stall, req_data       accepted: valid & !stall
//  result    res_valid, res_stall, res_data       accepted: valid & !stall
//  config    psel, penable, pwrite, paddr, ...    APB, pready tied high
//
//  Put, newline, read and no-op requests are handled by the engine after the
//  intake register. A scroll uses both ports of the screen RAM together:
//  a copy pass, a drain step, then a bottom-row fill. A clear fills every cell.
//  After reset a clearing pass writes blank cells; req_stall
//  stays high during it, config writes are taken as usual.
//  A result parked in the output register does not block the engine until
//  the next result is due; the command queue keeps intake running meanwhile.
//
`default_nettype none

module text_console_writer_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,

	// requests
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire tcw_pkg::req_t                 req_data,

	// results
	output logic                               res_valid,
	input  wire logic                          res_stall,
	output tcw_pkg::res_t                      res_data,

	// register port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [tcw_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [tcw_pkg::PDATA_W-1:0]   pwdata,
	output logic [tcw_pkg::PDATA_W-1:0]        prdata,
	output logic                               pready
);

	logic [tcw_pkg::COLOUR_W-1:0]  text_colour_q;
	logic                          cursor_follow_q;
	logic                          cfg_write;
	logic [tcw_pkg::REG_IDX_W-1:0] reg_idx;

	logic          init_busy;
	logic          push;
	logic          q_full;
	tcw_pkg::cmd_t front_cmd;
	tcw_pkg::cmd_t head_cmd;
	logic          head_valid;
	logic          pop;

	// Registers sit on 4-byte boundaries; the low address bits are ignored.
	assign pready    = 1'b1;
	assign reg_idx   = paddr[2 +: tcw_pkg::REG_IDX_W];
	assign cfg_write = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_colour_q   <= tcw_pkg::RESET_COLOUR;
			cursor_follow_q <= tcw_pkg::RESET_FOLLOW;
		end else if (cfg_write) begin
			unique case (reg_idx)
				tcw_pkg::REG_TEXT_COLOUR:   text_colour_q   <= pwdata[tcw_pkg::COLOUR_W-1:0];
				tcw_pkg::REG_CURSOR_FOLLOW: cursor_follow_q <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			tcw_pkg::REG_TEXT_COLOUR:   prdata = tcw_pkg::PDATA_W'(text_colour_q);
			tcw_pkg::REG_CURSOR_FOLLOW: prdata = tcw_pkg::PDATA_W'(cursor_follow_q);
			default:                    prdata = '0;
		endcase
	end

	// front: register and decode requests
	tcw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.init_busy (init_busy),
		.q_full    (q_full),
		.push      (push),
		.cmd       (front_cmd)
	);

	// decoupling queue
	tcw_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (front_cmd),
		.full      (q_full),
		.pop       (pop),
		.head      (head_cmd),
		.not_empty (head_valid)
	);

	// back: cursor, screen RAM and result register
	tcw_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (head_cmd),
		.cmd_valid     (head_valid),
		.pop           (pop),
		.text_colour   (text_colour_q),
		.cursor_follow (cursor_follow_q),
		.init_busy     (init_busy),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.res_data      (res_data)
	);

endmodule

`default_nettype wire

// ----- hdl/tcw_checker.sv -----
// ---------------------------------------------------------------------------
// tcw_checker
// Port-level checks on the result channel of the console writer.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tcw_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          res_valid,
	input wire logic          res_stall,
	input wire tcw_pkg::res_t res_data
);

	`TCW_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(res_data), "stalled result changed")
	`TCW_ASSERT(a_cursor_range, clk, arst_n, !res_valid || (res_data.cursor_row < tcw_pkg::ROW_W'(tcw_pkg::ROWS) && res_data.cursor_column < tcw_pkg::COL_W'(tcw_pkg::COLUMNS)), "cursor off screen")
	`TCW_ASSERT(a_location, clk, arst_n, !res_valid || res_data.cursor_location == tcw_pkg::cell_loc(res_data.cursor_row, res_data.cursor_column), "cursor location mismatch")
	`TCW_ASSERT(a_scroll_pos, clk, arst_n, !(res_valid && res_data.scrolled) || (res_data.cursor_row == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1) && res_data.cursor_column == '0 && res_data.read_cell == '0), "scroll left cursor off last row start")

endmodule

bind text_console_writer_core tcw_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_data  (res_data)
);

`default_nettype wire
